>>> rtl/jts_pkg.sv
package jts_pkg;

    // default sizes
    localparam int MAX_LEXEME_DEF  = 256;
    localparam int LINE_BITS_DEF   = 20;
    localparam int QUEUE_DEPTH_DEF = 4;

    // word buffer and output clipping
    localparam int WORD_DEPTH   = 5;
    localparam int LEN_OUT_MAX  = 511;
    localparam int LINE_OUT_MAX = 1048575;

    // characters
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UE     = 8'h45;
    localparam logic [7:0] CH_UZ     = 8'h5A;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LE     = 8'h65;
    localparam logic [7:0] CH_LZ     = 8'h7A;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    typedef enum logic [3:0] {
        KIND_COLON    = 4'd0,
        KIND_LBRACE   = 4'd1,
        KIND_RBRACE   = 4'd2,
        KIND_LBRACKET = 4'd3,
        KIND_RBRACKET = 4'd4,
        KIND_COMMA    = 4'd5,
        KIND_STRING   = 4'd6,
        KIND_NUMBER   = 4'd7,
        KIND_TRUE     = 4'd8,
        KIND_FALSE    = 4'd9,
        KIND_NULL     = 4'd10,
        KIND_END      = 4'd11,
        KIND_ERROR    = 4'd12
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE   = 3'd0,
        ERR_CHAR   = 3'd1,
        ERR_UNTERM = 3'd2,
        ERR_LONG   = 3'd3,
        ERR_EOT    = 3'd4,
        ERR_WORD   = 3'd5
    } code_t;

    typedef enum logic [3:0] {
        M_IDLE,
        M_STR,
        M_STR_OVER,
        M_INT,
        M_DOT,
        M_FRAC,
        M_E,
        M_SIGN,
        M_EXP,
        M_WORD
    } mode_t;

    typedef struct packed {
        kind_t      kind;
        code_t      code;
        logic [7:0] bad;
    } tok_t;

    // all tokens caused by one input item
    typedef struct packed {
        logic [1:0]      count;
        tok_t [2:0]      tok;
        logic [8:0]      len;
        logic [19:0]     line;
    } bundle_t;

    function automatic tok_t make_tok(input kind_t kind, input code_t code,
                                      input logic [7:0] bad);
        tok_t t;
        t.kind = kind;
        t.code = code;
        t.bad  = bad;
        return t;
    endfunction

    // keyword lookup, KIND_ERROR when the word is no keyword
    function automatic kind_t word_kind(input logic [WORD_DEPTH-1:0][7:0] w,
                                        input logic is4, input logic is5,
                                        input logic too_long);
        kind_t k;
        logic [31:0] w4;
        logic [39:0] w5;
        w4 = {w[0], w[1], w[2], w[3]};
        w5 = {w[0], w[1], w[2], w[3], w[4]};
        k  = KIND_ERROR;
        if (!too_long && is4)
        begin
            if (w4 == "true" || w4 == "TRUE")
                k = KIND_TRUE;
            else if (w4 == "null" || w4 == "NULL")
                k = KIND_NULL;
        end
        else if (!too_long && is5)
        begin
            if (w5 == "false" || w5 == "FALSE")
                k = KIND_FALSE;
        end
        return k;
    endfunction

endpackage

>>> rtl/json_token_scanner.sv
// channel  direction  handshake            payload
// input    in         in_valid / in_stall   byte_in, end_of_text
// output   out        out_valid / out_stall token_kind, error_code, bad_byte,
//                                           lexeme_length, line_number, last_of_run
//
// one input transfer per cycle unless in_stall; an item that yields k tokens
// takes k output transfers (k is 0 to 3), the token queue absorbs bursts
// the classifier state loop (one byte, one state step) sets the input rate
// first token of an item goes through a queue slot, then the output register
// rst_n clears scan state, queue and out_valid at once; the line counter resets to 1
// in_stall rises only while the token queue is full
module json_token_scanner
    import jts_pkg::*;
#(
    parameter int MAX_LEXEME  = MAX_LEXEME_DEF,
    parameter int LINE_BITS   = LINE_BITS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    // input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  byte_in,
    input  logic        end_of_text,
    // output channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  token_kind,
    output logic [2:0]  error_code,
    output logic [7:0]  bad_byte,
    output logic [8:0]  lexeme_length,
    output logic [19:0] line_number,
    output logic        last_of_run
);

    // front to queue
    logic    push;
    logic    q_full;
    bundle_t push_data;

    // queue to back
    logic    pop;
    logic    head_valid;
    bundle_t head;

    // classifier: scan state, counters, keyword buffer; one byte per transfer
    jts_front #(
        .MAX_LEXEME (MAX_LEXEME),
        .LINE_BITS  (LINE_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .byte_in     (byte_in),
        .end_of_text (end_of_text),
        .q_full      (q_full),
        .push        (push),
        .bundle      (push_data)
    );

    // short queue of token bundles, decouples both sides
    jts_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    // token sequencer: unpacks a bundle one token per output transfer
    jts_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (head_valid),
        .head          (head),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .token_kind    (token_kind),
        .error_code    (error_code),
        .bad_byte      (bad_byte),
        .lexeme_length (lexeme_length),
        .line_number   (line_number),
        .last_of_run   (last_of_run)
    );

endmodule

>>> rtl/jts_front.sv
module jts_front
    import jts_pkg::*;
#(
    parameter int MAX_LEXEME = MAX_LEXEME_DEF,
    parameter int LINE_BITS  = LINE_BITS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] byte_in,
    input  logic       end_of_text,
    input  logic       q_full,
    output logic       push,
    output bundle_t    bundle
);

    localparam int LEX_W = $clog2(MAX_LEXEME + 1);
    localparam logic [LEX_W-1:0] LEX_MAX  = LEX_W'(MAX_LEXEME);
    localparam logic [LEX_W-1:0] WORD_LIM = LEX_W'(WORD_DEPTH);
    localparam logic [LINE_BITS-1:0] LINE_MAX = '1;

    mode_t                      mode_reg, mode_next;
    logic [LEX_W-1:0]           cnt_reg, cnt_next, cnt_inc;
    logic [LINE_BITS-1:0]       line_reg, line_next;
    logic                       tl_reg, tl_next;
    logic [WORD_DEPTH-1:0][7:0] word_reg;
    logic                       word_we;
    logic [2:0]                 word_idx;

    logic accept, eot, run_idle;
    logic c_dig, c_alpha, c_e, c_dot, c_sign, c_quote, c_ws, c_nl, c_punct;
    kind_t punct_kind;
    logic [1:0] n;
    tok_t [2:0] tok;
    logic [8:0] len;
    logic idle_has;
    tok_t idle_tok;

    function automatic logic [8:0] len_clip(input logic [LEX_W-1:0] v);
        return (32'(v) > 32'(LEN_OUT_MAX)) ? 9'(LEN_OUT_MAX) : 9'(v);
    endfunction

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign eot      = end_of_text;

    assign c_dig   = !eot && (byte_in inside {[CH_0:CH_9]});
    assign c_alpha = !eot && (byte_in inside {[CH_LA:CH_LZ], [CH_UA:CH_UZ]});
    assign c_e     = !eot && (byte_in inside {CH_LE, CH_UE});
    assign c_dot   = !eot && (byte_in == CH_DOT);
    assign c_sign  = !eot && (byte_in inside {CH_PLUS, CH_MINUS});
    assign c_quote = !eot && (byte_in == CH_QUOTE);
    assign c_ws    = !eot && (byte_in inside {CH_SPACE, CH_TAB});
    assign c_nl    = !eot && (byte_in == CH_NL);
    assign cnt_inc = (cnt_reg < LEX_MAX) ? cnt_reg + 1'b1 : cnt_reg;

    always_comb
    begin
        c_punct    = !eot;
        punct_kind = KIND_COLON;
        case (byte_in)
            CH_COLON:  punct_kind = KIND_COLON;
            CH_LBRACE: punct_kind = KIND_LBRACE;
            CH_RBRACE: punct_kind = KIND_RBRACE;
            CH_LBRACK: punct_kind = KIND_LBRACKET;
            CH_RBRACK: punct_kind = KIND_RBRACKET;
            CH_COMMA:  punct_kind = KIND_COMMA;
            default:   c_punct    = 1'b0;
        endcase
    end

    // byte ends the current lexeme and is scanned again as if in idle
    always_comb
    begin
        case (mode_reg)
            M_IDLE:  run_idle = 1'b1;
            M_INT:   run_idle = !(c_dig || c_dot || c_e);
            M_FRAC:  run_idle = !(c_dig || c_e);
            M_EXP:   run_idle = !c_dig;
            M_WORD:  run_idle = !c_alpha;
            default: run_idle = 1'b0;
        endcase
    end

    // next state
    always_comb
    begin
        mode_next = mode_reg;
        cnt_next  = cnt_reg;
        line_next = line_reg;
        tl_next   = tl_reg;
        word_we   = 1'b0;
        word_idx  = cnt_reg[2:0];
        if (run_idle)
        begin
            mode_next = M_IDLE;
            if (c_quote)
            begin
                mode_next = M_STR;
                cnt_next  = '0;
            end
            else if (c_dig)
            begin
                mode_next = M_INT;
                cnt_next  = LEX_W'(1);
            end
            else if (c_alpha)
            begin
                mode_next = M_WORD;
                cnt_next  = LEX_W'(1);
                tl_next   = 1'b0;
                word_we   = 1'b1;
                word_idx  = 3'd0;
            end
            else if (c_nl && line_reg != LINE_MAX)
            begin
                line_next = line_reg + 1'b1;
            end
        end
        else
        begin
            case (mode_reg)
                M_STR, M_STR_OVER:
                begin
                    if (eot || c_quote)
                        mode_next = M_IDLE;
                    else if (mode_reg == M_STR && cnt_reg < LEX_MAX)
                        cnt_next = cnt_reg + 1'b1;
                    else
                        mode_next = M_STR_OVER;
                end
                M_INT:
                begin
                    cnt_next = cnt_inc;
                    if (c_dot)
                        mode_next = M_DOT;
                    else if (c_e)
                        mode_next = M_E;
                end
                M_DOT:
                begin
                    if (c_dig)
                    begin
                        cnt_next  = cnt_inc;
                        mode_next = M_FRAC;
                    end
                    else
                        mode_next = M_IDLE;
                end
                M_FRAC:
                begin
                    cnt_next = cnt_inc;
                    if (c_e)
                        mode_next = M_E;
                end
                M_E:
                begin
                    if (c_sign)
                    begin
                        cnt_next  = cnt_inc;
                        mode_next = M_SIGN;
                    end
                    else if (c_dig)
                    begin
                        cnt_next  = cnt_inc;
                        mode_next = M_EXP;
                    end
                    else
                        mode_next = M_IDLE;
                end
                M_SIGN:
                begin
                    if (c_dig)
                    begin
                        cnt_next  = cnt_inc;
                        mode_next = M_EXP;
                    end
                    else
                        mode_next = M_IDLE;
                end
                M_EXP:
                begin
                    cnt_next = cnt_inc;
                end
                M_WORD:
                begin
                    if (cnt_reg < WORD_LIM)
                        word_we = 1'b1;
                    else
                        tl_next = 1'b1;
                    cnt_next = cnt_inc;
                end
                default:
                begin
                    mode_next = M_IDLE;
                end
            endcase
        end
    end

    // token emitted by the idle scan of this byte
    always_comb
    begin
        idle_has = 1'b1;
        idle_tok = make_tok(KIND_ERROR, ERR_CHAR, byte_in);
        if (eot)
            idle_tok = make_tok(KIND_END, ERR_NONE, 8'h00);
        else if (c_punct)
            idle_tok = make_tok(punct_kind, ERR_NONE, 8'h00);
        else if (c_ws || c_nl || c_quote || c_dig || c_alpha)
            idle_has = 1'b0;
    end

    // tokens of this item
    always_comb
    begin
        n   = 2'd0;
        len = 9'd0;
        tok = '0;
        case (mode_reg)
            M_STR, M_STR_OVER:
            begin
                if (eot)
                begin
                    tok[0] = make_tok(KIND_ERROR, ERR_UNTERM, 8'h00);
                    tok[1] = make_tok(KIND_END, ERR_NONE, 8'h00);
                    n      = 2'd2;
                end
                else if (c_quote)
                begin
                    tok[0] = (mode_reg == M_STR) ? make_tok(KIND_STRING, ERR_NONE, 8'h00)
                                                 : make_tok(KIND_ERROR, ERR_LONG, 8'h00);
                    len    = len_clip(cnt_reg);
                    n      = 2'd1;
                end
            end
            M_INT, M_FRAC, M_EXP:
            begin
                if (run_idle)
                begin
                    tok[0] = make_tok(KIND_NUMBER, ERR_NONE, 8'h00);
                    len    = len_clip(cnt_reg);
                    n      = 2'd1;
                end
            end
            M_DOT, M_E, M_SIGN:
            begin
                if (mode_reg == M_DOT && c_dot)
                begin
                    // second dot closes the number and is reported twice
                    tok[0] = make_tok(KIND_NUMBER, ERR_NONE, 8'h00);
                    tok[1] = make_tok(KIND_ERROR, ERR_CHAR, CH_DOT);
                    tok[2] = make_tok(KIND_ERROR, ERR_CHAR, CH_DOT);
                    len    = len_clip((cnt_reg != '0) ? cnt_reg - 1'b1 : cnt_reg);
                    n      = 2'd3;
                end
                else if (mode_next == M_IDLE)
                begin
                    if (eot)
                    begin
                        tok[0] = make_tok(KIND_ERROR, ERR_EOT, 8'h00);
                        tok[1] = make_tok(KIND_END, ERR_NONE, 8'h00);
                        n      = 2'd2;
                    end
                    else
                    begin
                        tok[0] = make_tok(KIND_ERROR, ERR_CHAR, byte_in);
                        n      = 2'd1;
                    end
                end
            end
            M_WORD:
            begin
                if (run_idle)
                begin
                    tok[0] = make_tok(word_kind(word_reg, cnt_reg == LEX_W'(4),
                                                cnt_reg == LEX_W'(5), tl_reg),
                                      ERR_NONE, 8'h00);
                    if (tok[0].kind == KIND_ERROR)
                        tok[0].code = ERR_WORD;
                    n = 2'd1;
                end
            end
            default:
            begin
                n = 2'd0;
            end
        endcase
        if (run_idle && idle_has)
        begin
            if (n == 2'd0)
                tok[0] = idle_tok;
            else
                tok[1] = idle_tok;
            n = n + 2'd1;
        end
    end

    assign push         = accept && (n != 2'd0);
    assign bundle.count = n;
    assign bundle.tok   = tok;
    assign bundle.len   = len;
    assign bundle.line  = (32'(line_reg) > 32'(LINE_OUT_MAX)) ? 20'(LINE_OUT_MAX)
                                                               : 20'(line_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_IDLE;
            cnt_reg  <= '0;
            line_reg <= LINE_BITS'(1);
            tl_reg   <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            cnt_reg  <= cnt_next;
            line_reg <= line_next;
            tl_reg   <= tl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && word_we)
            word_reg[word_idx] <= byte_in;
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= LEX_MAX)
        else $error("lexeme count above limit");
    a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        line_reg != '0)
        else $error("line counter wrapped to zero");
`endif

endmodule

>>> rtl/jts_queue.sv
module jts_queue
    import jts_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  bundle_t push_data,
    output logic    full,
    input  logic    pop,
    output logic    head_valid,
    output bundle_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    bundle_t          slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign full       = (cnt_reg == CNT_FULL);
    assign head_valid = (cnt_reg != '0);
    assign head       = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && !head_valid))
        else $error("queue read while empty");
`endif

endmodule

>>> rtl/jts_back.sv
module jts_back
    import jts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        head_valid,
    input  bundle_t     head,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  token_kind,
    output logic [2:0]  error_code,
    output logic [7:0]  bad_byte,
    output logic [8:0]  lexeme_length,
    output logic [19:0] line_number,
    output logic        last_of_run
);

    logic        out_valid_reg;
    tok_t        tok_reg;
    logic [8:0]  len_reg;
    logic [19:0] line_reg;
    logic        last_reg;
    logic [1:0]  idx_reg, idx_next;
    logic        load, last;
    tok_t        cur_tok;

    assign load = head_valid && (!out_valid_reg || !out_stall);
    assign last = (idx_reg == head.count - 2'd1);
    assign pop  = load && last;

    always_comb
    begin
        case (idx_reg)
            2'd0:    cur_tok = head.tok[0];
            2'd1:    cur_tok = head.tok[1];
            default: cur_tok = head.tok[2];
        endcase
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (load)
            idx_next = last ? 2'd0 : idx_reg + 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end
        else
        begin
            if (!out_valid_reg || !out_stall)
                out_valid_reg <= head_valid;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            tok_reg  <= cur_tok;
            len_reg  <= (idx_reg == 2'd0) ? head.len : 9'd0;
            line_reg <= head.line;
            last_reg <= last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign token_kind    = tok_reg.kind;
    assign error_code    = tok_reg.code;
    assign bad_byte      = tok_reg.bad;
    assign lexeme_length = len_reg;
    assign line_number   = line_reg;
    assign last_of_run   = last_reg;

`ifndef SYNTHESIS
    a_idx_in_bundle: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> (idx_reg < head.count))
        else $error("token index beyond bundle");
`endif

endmodule

>>> test/tb_json_token_scanner.sv
module tb_json_token_scanner;
    import jts_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // run-length guard, far above the slowest legal run
    localparam int CYCLE_LIMIT = 250000;
    localparam int MAX_LEX     = MAX_LEXEME_DEF;
    localparam int LINE_LIMIT  = (1 << LINE_BITS_DEF) - 1;

    // one byte of stimulus; typed rows carry a hand-written first token
    typedef struct packed {
        logic [7:0] b;
        logic       eot;
        logic       typed;
        kind_t      kind;
        code_t      code;
        logic [7:0] bad;
    } stim_row_t;

    // one token as it leaves the block
    typedef struct packed {
        kind_t       kind;
        code_t       code;
        logic [7:0]  bad;
        logic [8:0]  len;
        logic [19:0] line;
        logic        last;
    } token_rec_t;

    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LN = 8'h4E;
    localparam logic [7:0] CH_LU = 8'h55;
    localparam logic [7:0] CH_LL = 8'h4C;
    localparam logic [7:0] CH_X  = 8'h78;
    localparam logic [7:0] CH_1  = 8'h31;
    localparam logic [7:0] CH_7  = 8'h37;

    // directed opening: punctuation, odd bytes, newline inside a string,
    // double dot, bad byte after an exponent sign, upper-case keyword,
    // end inside a string and a repeated end marker
    localparam stim_row_t DIR_ROWS [0:26] = '{
        '{CH_LBRACE, 1'b0, 1'b1, KIND_LBRACE,   ERR_NONE,   8'h00},
        '{CH_RBRACE, 1'b0, 1'b1, KIND_RBRACE,   ERR_NONE,   8'h00},
        '{CH_LBRACK, 1'b0, 1'b1, KIND_LBRACKET, ERR_NONE,   8'h00},
        '{CH_RBRACK, 1'b0, 1'b1, KIND_RBRACKET, ERR_NONE,   8'h00},
        '{CH_COLON,  1'b0, 1'b1, KIND_COLON,    ERR_NONE,   8'h00},
        '{CH_COMMA,  1'b0, 1'b1, KIND_COMMA,    ERR_NONE,   8'h00},
        '{8'h00,     1'b0, 1'b1, KIND_ERROR,    ERR_CHAR,   8'h00},
        '{8'hFF,     1'b0, 1'b1, KIND_ERROR,    ERR_CHAR,   8'hFF},
        '{CH_CR,     1'b0, 1'b1, KIND_ERROR,    ERR_CHAR,   CH_CR},
        '{CH_NL,     1'b0, 1'b0, KIND_COLON,    ERR_NONE,   8'h00},
        '{CH_QUOTE,  1'b0, 1'b0, KIND_COLON,    ERR_NONE,   8'h00},
        '{CH_NL,     1'b0, 1'b0, KIND_COLON,    ERR_NONE,   8'h00},
        '{CH_QUOTE,  1'b0, 1'b0, KIND_COLON,    ERR_NONE,   8'h00},
        '{CH_1,      1'b0, 1'b0, KIND_COLON,    ERR_NONE,   8'h00},
        '{CH_DOT,    1'b0, 1'b0, KIND_COLON,    ERR_NONE,   8'h00},
        '{CH_DOT,    1'b0, 1'b0, KIND_COLON,    ERR_NONE,   8'h00},
        '{CH_7,      1'b0, 1'b0, KIND_COLON,    ERR_NONE,   8'h00},
        '{CH_LE,     1'b0, 1'b0, KIND_COLON,    ERR_NONE,   8'h00},
        '{CH_PLUS,   1'b0, 1'b0, KIND_COLON,    ERR_NONE,   8'h00},
        '{CH_X,      1'b0, 1'b1, KIND_ERROR,    ERR_CHAR,   CH_X},
        '{CH_LN,     1'b0, 1'b0, KIND_COLON,    ERR_NONE,   8'h00},
        '{CH_LU,     1'b0, 1'b0, KIND_COLON,    ERR_NONE,   8'h00},
        '{CH_LL,     1'b0, 1'b0, KIND_COLON,    ERR_NONE,   8'h00},
        '{CH_LL,     1'b0, 1'b0, KIND_COLON,    ERR_NONE,   8'h00},
        '{CH_QUOTE,  1'b0, 1'b1, KIND_NULL,     ERR_NONE,   8'h00},
        '{8'h5A,     1'b1, 1'b1, KIND_ERROR,    ERR_UNTERM, 8'h00},
        '{8'h00,     1'b1, 1'b1, KIND_END,      ERR_NONE,   8'h00}
    };

    localparam logic [7:0] PUNCT [0:5] = '{CH_COLON, CH_LBRACE, CH_RBRACE,
                                           CH_LBRACK, CH_RBRACK, CH_COMMA};
    localparam logic [7:0] BLANKS [0:2] = '{CH_SPACE, CH_TAB, CH_NL};

    string keywords [0:5] = '{"true", "TRUE", "false", "FALSE", "null", "NULL"};

    // idle mix per phase: none, sender only, receiver only, both
    int gap_tab   [0:3] = '{0, 68, 0, 36};
    int stall_tab [0:3] = '{0, 0, 68, 36};

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  byte_in;
    logic        end_of_text;
    logic        out_valid;
    logic        out_stall;
    logic [3:0]  token_kind;
    logic [2:0]  error_code;
    logic [7:0]  bad_byte;
    logic [8:0]  lexeme_length;
    logic [19:0] line_number;
    logic        last_of_run;

    // scanner shadow state
    mode_t       cur_mode;
    int unsigned lex_cnt;
    int unsigned line_cnt;
    logic [7:0]  word_buf [0:4];
    logic        word_long;
    int          step_start;

    token_rec_t  expected_toks [$];
    stim_row_t   stim_notes [$];
    int          mismatch_cnt;
    int          gap_pct;
    int          stall_pct;
    int          random_sent;
    int          cycle_cnt;

    // monitor scratch
    stim_row_t   note;
    int          base_idx;
    token_rec_t  tmp_tok;

    json_token_scanner dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .byte_in       (byte_in),
        .end_of_text   (end_of_text),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .token_kind    (token_kind),
        .error_code    (error_code),
        .bad_byte      (bad_byte),
        .lexeme_length (lexeme_length),
        .line_number   (line_number),
        .last_of_run   (last_of_run)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // shadow scanner: works out the tokens that one byte should cause
    // ------------------------------------------------------------------

    function automatic bit is_digit(input logic [7:0] c);
        return c >= CH_0 && c <= CH_9;
    endfunction

    function automatic bit is_letter(input logic [7:0] c);
        return (c >= CH_LA && c <= CH_LZ) || (c >= CH_UA && c <= CH_UZ);
    endfunction

    // at most three tokens per byte; length and line are clipped to port width
    function automatic void push_token(input kind_t k, input code_t c,
                                       input logic [7:0] bb, input int unsigned n);
        token_rec_t t;
        if (expected_toks.size() - step_start >= 3)
            return;
        t.kind = k;
        t.code = c;
        t.bad  = bb;
        t.len  = (n > LEN_OUT_MAX) ? 9'(LEN_OUT_MAX) : 9'(n);
        t.line = (line_cnt > LINE_OUT_MAX) ? 20'(LINE_OUT_MAX) : 20'(line_cnt);
        t.last = 1'b0;
        expected_toks.push_back(t);
    endfunction

    function automatic void count_char();
        if (lex_cnt < MAX_LEX)
            lex_cnt++;
    endfunction

    // byte seen with no token open (also the re-scan after a number or word)
    function automatic void lex_idle_byte(input logic [7:0] b, input logic e);
        cur_mode = M_IDLE;
        if (e)
        begin
            push_token(KIND_END, ERR_NONE, 8'h00, 0);
            return;
        end
        case (b)
            CH_SPACE, CH_TAB: ;
            CH_NL:
                if (line_cnt < LINE_LIMIT)
                    line_cnt++;
            CH_COLON:  push_token(KIND_COLON, ERR_NONE, 8'h00, 0);
            CH_LBRACE: push_token(KIND_LBRACE, ERR_NONE, 8'h00, 0);
            CH_RBRACE: push_token(KIND_RBRACE, ERR_NONE, 8'h00, 0);
            CH_LBRACK: push_token(KIND_LBRACKET, ERR_NONE, 8'h00, 0);
            CH_RBRACK: push_token(KIND_RBRACKET, ERR_NONE, 8'h00, 0);
            CH_COMMA:  push_token(KIND_COMMA, ERR_NONE, 8'h00, 0);
            CH_QUOTE:
            begin
                cur_mode = M_STR;
                lex_cnt  = 0;
            end
            default:
            begin
                if (is_digit(b))
                begin
                    cur_mode = M_INT;
                    lex_cnt  = 1;
                end
                else if (is_letter(b))
                begin
                    cur_mode    = M_WORD;
                    lex_cnt     = 1;
                    word_long   = 1'b0;
                    word_buf[0] = b;
                end
                else
                    push_token(KIND_ERROR, ERR_CHAR, b, 0);
            end
        endcase
    endfunction

    function automatic void close_number(input logic [7:0] b, input logic e);
        push_token(KIND_NUMBER, ERR_NONE, 8'h00, lex_cnt);
        lex_idle_byte(b, e);
    endfunction

    function automatic void number_fault(input logic [7:0] b, input logic e);
        cur_mode = M_IDLE;
        if (e)
        begin
            push_token(KIND_ERROR, ERR_EOT, 8'h00, 0);
            push_token(KIND_END, ERR_NONE, 8'h00, 0);
        end
        else
            push_token(KIND_ERROR, ERR_CHAR, b, 0);
    endfunction

    function automatic void close_word(input logic [7:0] b, input logic e);
        kind_t       k;
        logic [31:0] w4;
        logic [39:0] w5;
        k  = KIND_ERROR;
        w4 = {word_buf[0], word_buf[1], word_buf[2], word_buf[3]};
        w5 = {w4, word_buf[4]};
        if (!word_long)
        begin
            case (lex_cnt)
                4:
                    case (w4)
                        "true", "TRUE": k = KIND_TRUE;
                        "null", "NULL": k = KIND_NULL;
                        default: ;
                    endcase
                5:
                    case (w5)
                        "false", "FALSE": k = KIND_FALSE;
                        default: ;
                    endcase
                default: ;
            endcase
        end
        if (k == KIND_ERROR)
            push_token(KIND_ERROR, ERR_WORD, 8'h00, 0);
        else
            push_token(k, ERR_NONE, 8'h00, 0);
        lex_idle_byte(b, e);
    endfunction

    // one accepted byte: advance the shadow state, queue its tokens
    function automatic void predict_step(input logic [7:0] b, input logic e);
        bit         dig;
        bit         expo;
        token_rec_t t;
        dig        = !e && is_digit(b);
        expo       = !e && (b == CH_LE || b == CH_UE);
        step_start = expected_toks.size();
        case (cur_mode)
            M_STR, M_STR_OVER:
            begin
                if (e)
                begin
                    cur_mode = M_IDLE;
                    push_token(KIND_ERROR, ERR_UNTERM, 8'h00, 0);
                    push_token(KIND_END, ERR_NONE, 8'h00, 0);
                end
                else if (b == CH_QUOTE)
                begin
                    if (cur_mode == M_STR)
                        push_token(KIND_STRING, ERR_NONE, 8'h00, lex_cnt);
                    else
                        push_token(KIND_ERROR, ERR_LONG, 8'h00, lex_cnt);
                    cur_mode = M_IDLE;
                end
                else if (cur_mode == M_STR && lex_cnt < MAX_LEX)
                    lex_cnt++;
                else
                    cur_mode = M_STR_OVER;
            end
            M_INT:
            begin
                if (dig)
                    count_char();
                else if (!e && b == CH_DOT)
                begin
                    count_char();
                    cur_mode = M_DOT;
                end
                else if (expo)
                begin
                    count_char();
                    cur_mode = M_E;
                end
                else
                    close_number(b, e);
            end
            M_DOT:
            begin
                if (dig)
                begin
                    count_char();
                    cur_mode = M_FRAC;
                end
                else if (!e && b == CH_DOT)
                begin
                    // second dot: the number without its dot, then two dot errors
                    cur_mode = M_IDLE;
                    push_token(KIND_NUMBER, ERR_NONE, 8'h00, (lex_cnt > 0) ? lex_cnt - 1 : 0);
                    push_token(KIND_ERROR, ERR_CHAR, CH_DOT, 0);
                    push_token(KIND_ERROR, ERR_CHAR, CH_DOT, 0);
                end
                else
                    number_fault(b, e);
            end
            M_FRAC:
            begin
                if (dig)
                    count_char();
                else if (expo)
                begin
                    count_char();
                    cur_mode = M_E;
                end
                else
                    close_number(b, e);
            end
            M_E:
            begin
                if (!e && (b == CH_PLUS || b == CH_MINUS))
                begin
                    count_char();
                    cur_mode = M_SIGN;
                end
                else if (dig)
                begin
                    count_char();
                    cur_mode = M_EXP;
                end
                else
                    number_fault(b, e);
            end
            M_SIGN:
            begin
                if (dig)
                begin
                    count_char();
                    cur_mode = M_EXP;
                end
                else
                    number_fault(b, e);
            end
            M_EXP:
            begin
                if (dig)
                    count_char();
                else
                    close_number(b, e);
            end
            M_WORD:
            begin
                if (!e && is_letter(b))
                begin
                    if (lex_cnt < WORD_DEPTH)
                        word_buf[lex_cnt] = b;
                    else
                        word_long = 1'b1;
                    count_char();
                end
                else
                    close_word(b, e);
            end
            default:
                lex_idle_byte(b, e);
        endcase
        // flag the final token of this byte
        if (expected_toks.size() > step_start)
        begin
            t      = expected_toks[expected_toks.size() - 1];
            t.last = 1'b1;
            expected_toks[expected_toks.size() - 1] = t;
        end
    endfunction

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        mismatch_cnt++;
        $display("%0t ns: mismatch: %s", $time, msg);
    endtask

    task automatic check_token();
        token_rec_t got;
        token_rec_t want;
        got.kind = kind_t'(token_kind);
        got.code = code_t'(error_code);
        got.bad  = bad_byte;
        got.len  = lexeme_length;
        got.line = line_number;
        got.last = last_of_run;
        if (expected_toks.size() == 0)
            report_mismatch($sformatf("token kind %0d with nothing expected", token_kind));
        else
        begin
            want = expected_toks.pop_front();
            if (got !== want)
                report_mismatch($sformatf(
                    "got kind %0d code %0d bad %02h len %0d line %0d last %0b, want %0d %0d %02h %0d %0d %0b",
                    got.kind, got.code, got.bad, got.len, got.line, got.last,
                    want.kind, want.code, want.bad, want.len, want.line, want.last));
        end
    endtask

    // both channels sampled with their pre-edge values
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            note     = stim_notes.pop_front();
            base_idx = expected_toks.size();
            predict_step(byte_in, end_of_text);
            // directed rows with a hand-written first token override the prediction
            if (note.typed && expected_toks.size() > base_idx)
            begin
                tmp_tok      = expected_toks[base_idx];
                tmp_tok.kind = note.kind;
                tmp_tok.code = note.code;
                tmp_tok.bad  = note.bad;
                expected_toks[base_idx] = tmp_tok;
            end
        end
        if (rst_n && out_valid && !out_stall)
            check_token();
    end

    // receiver back-pressure, random at the phase's rate
    always @(posedge clk)
        out_stall <= ($urandom_range(0, 99) < stall_pct);

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    // random sender gaps, then hold the byte until the transfer happens
    task automatic send_row(input stim_row_t r);
        while ($urandom_range(0, 99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        stim_notes.push_back(r);
        in_valid    <= 1'b1;
        byte_in     <= r.b;
        end_of_text <= r.eot;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        // spaces and tabs are simply skipped by the block, so they do not count
        if (r.eot || (r.b != CH_SPACE && r.b != CH_TAB))
            random_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b, input logic e);
        stim_row_t r;
        r       = '0;
        r.b     = b;
        r.eot   = e;
        r.typed = 1'b0;
        r.kind  = KIND_COLON;
        r.code  = ERR_NONE;
        send_row(r);
    endtask

    function automatic logic [7:0] rand_digit();
        return 8'(CH_0 + $urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] rand_letter();
        if ($urandom_range(0, 1) == 0)
            return 8'(CH_LA + $urandom_range(0, 25));
        return 8'(CH_UA + $urandom_range(0, 25));
    endfunction

    // any byte but the closing quote, with the odd newline
    function automatic logic [7:0] rand_text();
        logic [7:0] c;
        if ($urandom_range(0, 9) == 0)
            return CH_NL;
        c = 8'($urandom_range(0, 255));
        while (c == CH_QUOTE)
            c = 8'($urandom_range(0, 255));
        return c;
    endfunction

    task automatic send_digits(input int n);
        repeat (n) send_byte(rand_digit(), 1'b0);
    endtask

    // integer part, optional fraction, optional exponent with an optional sign
    task automatic send_number();
        send_digits($urandom_range(1, 3));
        if ($urandom_range(0, 1) == 1)
        begin
            send_byte(CH_DOT, 1'b0);
            send_digits($urandom_range(1, 3));
        end
        if ($urandom_range(0, 9) < 4)
        begin
            send_byte($urandom_range(0, 1) ? CH_LE : CH_UE, 1'b0);
            case ($urandom_range(0, 2))
                0: send_byte(CH_PLUS, 1'b0);
                1: send_byte(CH_MINUS, 1'b0);
                default: ;
            endcase
            send_digits($urandom_range(1, 2));
        end
    endtask

    // one lexical unit: mostly well-formed tokens, some noise and broken ones
    task automatic gen_sequence();
        int         pick;
        logic [7:0] c;
        string      kw;
        pick = $urandom_range(0, 99);
        if (pick < 12)
            send_byte(PUNCT[$urandom_range(0, 5)], 1'b0);
        else if (pick < 20)
            send_byte(BLANKS[$urandom_range(0, 2)], 1'b0);
        else if (pick < 38)
        begin
            send_byte(CH_QUOTE, 1'b0);
            repeat ($urandom_range(0, 8)) send_byte(rand_text(), 1'b0);
            send_byte(CH_QUOTE, 1'b0);
        end
        else if (pick < 60)
            send_number();
        else if (pick < 72)
        begin
            kw = keywords[$urandom_range(0, 5)];
            for (int i = 0; i < kw.len(); i++)
                send_byte(kw[i], 1'b0);
        end
        else if (pick < 78)
            repeat ($urandom_range(1, 7)) send_byte(rand_letter(), 1'b0);
        else if (pick < 86)
            send_byte(8'($urandom_range(0, 255)), 1'b0);
        else if (pick < 92)
        begin
            // number broken after its dot, its e, or its exponent sign
            send_digits($urandom_range(1, 2));
            case ($urandom_range(0, 2))
                0: send_byte(CH_DOT, 1'b0);
                1: send_byte(CH_LE, 1'b0);
                default:
                begin
                    send_byte(CH_UE, 1'b0);
                    send_byte(CH_MINUS, 1'b0);
                end
            endcase
            c = 8'($urandom_range(0, 255));
            while (is_digit(c))
                c = 8'($urandom_range(0, 255));
            send_byte(c, 1'b0);
        end
        else if (pick < 97)
        begin
            // end marker landing inside some token, or between tokens
            case ($urandom_range(0, 6))
                0: ;
                1: send_digits($urandom_range(1, 3));
                2:
                begin
                    send_digits(1);
                    send_byte(CH_DOT, 1'b0);
                end
                3:
                begin
                    send_digits(1);
                    send_byte(CH_UE, 1'b0);
                end
                4:
                begin
                    send_digits(1);
                    send_byte(CH_LE, 1'b0);
                    send_byte(CH_MINUS, 1'b0);
                end
                5:
                begin
                    send_byte(CH_QUOTE, 1'b0);
                    repeat ($urandom_range(0, 3)) send_byte(rand_text(), 1'b0);
                end
                default:
                    repeat ($urandom_range(1, 6)) send_byte(rand_letter(), 1'b0);
            endcase
            send_byte(8'($urandom_range(0, 255)), 1'b1);
        end
        else
            send_byte(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // timeout guard
    initial
    begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        byte_in      = 8'h00;
        end_of_text  = 1'b0;
        out_stall    = 1'b0;
        gap_pct      = 0;
        stall_pct    = 0;
        mismatch_cnt = 0;
        random_sent  = 0;
        step_start   = 0;
        // shadow state after reset
        cur_mode     = M_IDLE;
        lex_cnt      = 0;
        line_cnt     = 1;
        word_long    = 1'b0;
        for (int i = 0; i < WORD_DEPTH; i++)
            word_buf[i] = 8'h00;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table first, no idling
        foreach (DIR_ROWS[i])
            send_row(DIR_ROWS[i]);

        // random part, one idle mix per phase
        for (int p = 0; p < 4; p++)
        begin
            gap_pct     = gap_tab[p];
            stall_pct   = stall_tab[p];
            random_sent = 0;
            while (random_sent < 30)
                gen_sequence();
        end
        in_valid <= 1'b0;

        // drain, then a short tail to catch any stray transfer
        while (expected_toks.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);

        if (mismatch_cnt == 0 && expected_toks.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

>>> sim.f
rtl/jts_pkg.sv
rtl/jts_front.sv
rtl/jts_queue.sv
rtl/jts_back.sv
rtl/json_token_scanner.sv
test/tb_json_token_scanner.sv
